@@ rtl/pgmf_pkg.sv @@
package pgmf_pkg;

	// Width of the body byte counter, 16 to 32 bits.
	localparam int unsigned LEN_WIDTH = 32;

	// Width of the length field on the wire.
	localparam int unsigned LEN_ACC_W = 32;

	localparam logic [LEN_ACC_W-1:0] HDR_LEN_BYTES = LEN_ACC_W'(4);
	localparam logic [LEN_ACC_W-1:0] BODY_MAX =
		LEN_ACC_W'((64'd1 << LEN_WIDTH) - 64'd1);

	// ReadyForQuery message type, 'Z'.
	localparam logic [7:0] READY_TYPE = 8'h5A;

	localparam logic KIND_STATUS    = 1'b0;
	localparam logic KIND_MALFORMED = 1'b1;

	typedef enum logic [2:0] {
		HDR_TYPE = 3'd0,
		HDR_LEN1 = 3'd1,
		HDR_LEN2 = 3'd2,
		HDR_LEN3 = 3'd3,
		HDR_LEN4 = 3'd4,
		HDR_BODY = 3'd5
	} hdr_state_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] xact_status;
		logic [7:0] msg_type;
	} pgmf_result_t;

endpackage

@@ rtl/pgmf_byte_if.sv @@
interface pgmf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/pgmf_result_if.sv @@
interface pgmf_result_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] xact_status;
	logic [7:0] msg_type;

	modport source (output valid, output result_kind, output xact_status, output msg_type,
		input ready);
	modport sink (input valid, input result_kind, input xact_status, input msg_type,
		output ready);
endinterface

@@ rtl/pgmf_parse.sv @@
module pgmf_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              data_byte,
	output logic                    res_valid,
	output pgmf_pkg::pgmf_result_t  res
);

	pgmf_pkg::hdr_state_t hdr_q, hdr_d;
	logic [7:0]                       type_q, type_d;
	logic [pgmf_pkg::LEN_ACC_W-1:0]   len_q, len_d;
	logic [pgmf_pkg::LEN_WIDTH-1:0]   body_q, body_d;
	logic                             pend_q, pend_d;

	logic [pgmf_pkg::LEN_ACC_W-1:0]   len_full;
	logic [pgmf_pkg::LEN_ACC_W-1:0]   body_raw;
	logic [pgmf_pkg::LEN_ACC_W-1:0]   body_sat;
	logic [pgmf_pkg::LEN_WIDTH-1:0]   body_dec;

	assign len_full = {len_q[pgmf_pkg::LEN_ACC_W-9:0], data_byte};
	assign body_raw = len_full - pgmf_pkg::HDR_LEN_BYTES;
	assign body_sat = (body_raw > pgmf_pkg::BODY_MAX) ? pgmf_pkg::BODY_MAX : body_raw;
	assign body_dec = body_q - {{(pgmf_pkg::LEN_WIDTH-1){1'b0}}, (body_q != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= pgmf_pkg::HDR_TYPE;
			type_q <= '0;
			len_q  <= '0;
			body_q <= '0;
			pend_q <= 1'b0;
		end else if (take) begin
			hdr_q  <= hdr_d;
			type_q <= type_d;
			len_q  <= len_d;
			body_q <= body_d;
			pend_q <= pend_d;
		end
	end

	always_comb begin
		hdr_d     = hdr_q;
		type_d    = type_q;
		len_d     = len_q;
		body_d    = body_q;
		pend_d    = pend_q;
		res_valid = 1'b0;
		res       = '{result_kind: pgmf_pkg::KIND_STATUS, xact_status: data_byte,
			msg_type: type_q};
		case (hdr_q)
			pgmf_pkg::HDR_LEN1: begin
				len_d = len_full;
				hdr_d = pgmf_pkg::HDR_LEN2;
			end
			pgmf_pkg::HDR_LEN2: begin
				len_d = len_full;
				hdr_d = pgmf_pkg::HDR_LEN3;
			end
			pgmf_pkg::HDR_LEN3: begin
				len_d = len_full;
				hdr_d = pgmf_pkg::HDR_LEN4;
			end
			pgmf_pkg::HDR_LEN4: begin
				len_d = len_full;
				if (len_full < pgmf_pkg::HDR_LEN_BYTES) begin
					// short length: flag it and treat the body as empty
					res_valid       = 1'b1;
					res.result_kind = pgmf_pkg::KIND_MALFORMED;
					res.xact_status = '0;
					body_d          = '0;
					pend_d          = 1'b0;
					hdr_d           = pgmf_pkg::HDR_TYPE;
				end else begin
					body_d = body_sat[pgmf_pkg::LEN_WIDTH-1:0];
					if (body_sat == '0) begin
						pend_d = 1'b0;
						hdr_d  = pgmf_pkg::HDR_TYPE;
					end else begin
						pend_d = (type_q == pgmf_pkg::READY_TYPE);
						hdr_d  = pgmf_pkg::HDR_BODY;
					end
				end
			end
			pgmf_pkg::HDR_BODY: begin
				if (pend_q) begin
					res_valid = 1'b1;
					pend_d    = 1'b0;
				end
				body_d = body_dec;
				if (body_dec == '0) begin
					hdr_d = pgmf_pkg::HDR_TYPE;
				end
			end
			default: begin
				// type byte, also the unused codes
				type_d = data_byte;
				len_d  = '0;
				pend_d = 1'b0;
				hdr_d  = pgmf_pkg::HDR_LEN1;
			end
		endcase
	end

endmodule

@@ rtl/pgmf_out_buf.sv @@
module pgmf_out_buf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pgmf_pkg::pgmf_result_t  push_res,
	output logic                    can_take,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pgmf_pkg::pgmf_result_t  out_res
);

	logic                   main_valid_q;
	logic                   skid_valid_q;
	pgmf_pkg::pgmf_result_t main_q;
	pgmf_pkg::pgmf_result_t skid_q;
	logic                   pop;
	logic                   main_free;

	assign pop       = main_valid_q && out_ready;
	assign main_free = !main_valid_q || pop;
	assign can_take  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_free) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_free) begin
				main_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

endmodule

@@ rtl/pg_message_framer_unit.sv @@
// Message framer for the server-to-client stream of the PostgreSQL wire protocol.
// Channels: stream (sink) carries one protocol byte per transfer; result (source)
// carries one report per transfer: the transaction status of a ReadyForQuery ('Z')
// message, or a flag for a message whose length field is below four.
// Throughput: one byte per cycle while the output buffer has room; the header/body
// tracker updates its counter and compares combinationally for each byte.
// Reports: a report is registered into the output buffer on the transfer of the byte
// that causes it (the status byte, or the last length byte), then offered on result.
// Most bytes cause no report; those transfers produce nothing on result.
// Reset: the framer expects a type byte, all counters clear, no report is held.
// Stall: the output buffer holds two reports. While the receiver stalls the framer
// keeps taking bytes; stream.ready drops only once both entries are occupied, and
// rises again in the cycle after the receiver takes one.
module pg_message_framer_unit (
	input  logic            clk,
	input  logic            arst_n,
	pgmf_byte_if.sink       stream,
	pgmf_result_if.source   result
);

	logic                   take;
	logic                   res_valid;
	logic                   can_take;
	logic                   out_valid;
	pgmf_pkg::pgmf_result_t res;
	pgmf_pkg::pgmf_result_t out_res;

	// accept a byte whenever the output buffer has room for a possible report
	assign stream.ready = can_take;
	assign take         = stream.valid && can_take;

	// header and body tracking, one byte per transfer
	pgmf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (stream.data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// register reports and absorb receiver stalls
	pgmf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_res  (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.out_res   (out_res)
	);

	assign result.valid       = out_valid;
	assign result.result_kind = out_res.result_kind;
	assign result.xact_status = out_res.xact_status;
	assign result.msg_type    = out_res.msg_type;

`ifndef SYNTHESIS
	// a malformed-length report never carries a status byte
	a_malformed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.result_kind == pgmf_pkg::KIND_MALFORMED)
		|-> (result.xact_status == 8'h00))
		else $error("malformed report carries a status byte");

	// a status report only ever comes from a ReadyForQuery message
	a_status_type: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.result_kind == pgmf_pkg::KIND_STATUS)
		|-> (result.msg_type == pgmf_pkg::READY_TYPE))
		else $error("status report for a message that is not ReadyForQuery");

	// after an accepted byte raises a report, result carries a valid report in the next cycle
	a_report_offered: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_valid |=> result.valid)
		else $error("report lost between framer and output buffer");
`endif

endmodule

@@ verif/tb_pg_message_framer_unit.sv @@
`timescale 1ns / 1ps

module tb_pg_message_framer_unit;
	import pgmf_pkg::*;

	// Quiet-cycle budget for the watchdog. The longest correct quiet stretch is the
	// long receiver hold-off plus one sender gap and one receiver stall. Allow
	// several times that.
	localparam int unsigned IDLE_LIMIT     = 1000;
	localparam int unsigned RX_HOLD_CYCLES = 150;
	// Settling time once nothing is owed: the report latency plus a full
	// receiver stall, so that a stray report would still be caught.
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned RANDOM_BYTES   = 760;

	// Transaction status bytes carried by a ReadyForQuery message.
	localparam logic [7:0] TXN_IDLE   = 8'h49;	// 'I'
	localparam logic [7:0] TXN_ACTIVE = 8'h54;	// 'T'
	localparam logic [7:0] TXN_FAILED = 8'h45;	// 'E'

	localparam pgmf_result_t NO_REPORT = '0;

	// How a stimulus row is checked: by the framer predictor, as a byte known to
	// give no report, or against a report typed into the row.
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_QUIET,
		CHK_REPORT
	} row_check_t;

	typedef struct packed {
		row_check_t   chk;
		logic [7:0]   data;
		pgmf_result_t want;
	} row_t;

	logic clk;
	logic arst_n;

	pgmf_byte_if   stream_if ();
	pgmf_result_if result_if ();

	pg_message_framer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if.sink),
		.result (result_if.source)
	);

	// Framer state as the testbench sees it: header position, the message type,
	// the length word and the body bytes still to skip.
	hdr_state_t           frm_pos        = HDR_TYPE;
	logic [7:0]           frm_type       = '0;
	logic [LEN_ACC_W-1:0] frm_len        = '0;
	logic [LEN_ACC_W-1:0] frm_left       = '0;
	logic                 frm_status_due = 1'b0;

	// Reports owed by the block, oldest first.
	pgmf_result_t pending_reports [$];
	row_t         directed_rows [$];

	int unsigned mismatches    = 0;
	int unsigned random_bytes  = 0;
	int unsigned idle_cycles   = 0;
	bit          tx_burst      = 1'b0;
	bit          rx_burst      = 1'b0;
	bit          hold_req      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the framer by one stream byte; return 1 when the byte yields a report.
	function automatic bit frame_byte(input logic [7:0] b, output pgmf_result_t rep);
		logic [LEN_ACC_W-1:0] body;
		bit                   fired;
		rep   = NO_REPORT;
		fired = 1'b0;
		case (frm_pos)
			HDR_LEN1, HDR_LEN2, HDR_LEN3, HDR_LEN4: begin
				// Length arrives big-endian; shift each byte in from the bottom.
				frm_len = {frm_len[LEN_ACC_W-9:0], b};
				if (frm_pos != HDR_LEN4) begin
					frm_pos = hdr_state_t'(frm_pos + 3'd1);
				end else if (frm_len < HDR_LEN_BYTES) begin
					// Length cannot even cover itself: flag it, treat the body as empty.
					rep.result_kind = KIND_MALFORMED;
					rep.xact_status = 8'h00;
					rep.msg_type    = frm_type;
					fired           = 1'b1;
					frm_left        = '0;
					frm_status_due  = 1'b0;
					frm_pos         = HDR_TYPE;
				end else begin
					body = frm_len - HDR_LEN_BYTES;
					if (body > BODY_MAX)
						body = BODY_MAX;
					frm_left = body;
					if (body == '0) begin
						// Empty body: no status byte follows, even for 'Z'.
						frm_status_due = 1'b0;
						frm_pos        = HDR_TYPE;
					end else begin
						frm_status_due = (frm_type == READY_TYPE);
						frm_pos        = HDR_BODY;
					end
				end
			end
			HDR_BODY: begin
				if (frm_status_due) begin
					rep.result_kind = KIND_STATUS;
					rep.xact_status = b;
					rep.msg_type    = frm_type;
					fired           = 1'b1;
					frm_status_due  = 1'b0;
				end
				if (frm_left != '0)
					frm_left = frm_left - 1'b1;
				if (frm_left == '0)
					frm_pos = HDR_TYPE;
			end
			default: begin
				// Type byte; the unused header positions land here as well.
				frm_type       = b;
				frm_len        = '0;
				frm_status_due = 1'b0;
				frm_pos        = HDR_LEN1;
			end
		endcase
		return fired;
	endfunction

	function automatic row_t row(input row_check_t chk, input logic [7:0] b,
			input pgmf_result_t want);
		row_t r;
		r.chk  = chk;
		r.data = b;
		r.want = want;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// Offer one byte after a random gap and hold it until the transfer; on the
	// transfer, advance the predictor and queue whatever report is owed.
	// Never lower valid right after a transfer: the next byte may follow at once.
	task automatic send_byte(input logic [7:0] b, input row_check_t chk,
			input pgmf_result_t want);
		int unsigned  gap;
		pgmf_result_t rep;
		bit           fired;
		if ($urandom_range(0, 63) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid     <= 1'b1;
		stream_if.data_byte <= b;
		do @(posedge clk); while (!stream_if.ready);
		fired = frame_byte(b, rep);
		case (chk)
			CHK_PREDICT: begin
				if (fired)
					pending_reports.push_back(rep);
			end
			CHK_REPORT: pending_reports.push_back(want);
			default: ;
		endcase
	endtask

	// Send one whole message: type, big-endian length, then the body. The first
	// body byte of a 'Z' message is usually a genuine status letter.
	task automatic send_message(input logic [7:0] mtype, input logic [31:0] mlen);
		logic [31:0] body_len;
		logic [7:0]  b;
		send_byte(mtype, CHK_PREDICT, NO_REPORT);
		for (int i = 3; i >= 0; i--)
			send_byte(mlen[8*i +: 8], CHK_PREDICT, NO_REPORT);
		body_len = (mlen < 32'd4) ? 32'd0 : mlen - 32'd4;
		for (int unsigned i = 0; i < body_len; i++) begin
			if (i == 0 && mtype == READY_TYPE && $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 2))
					0:       b = TXN_IDLE;
					1:       b = TXN_ACTIVE;
					default: b = TXN_FAILED;
				endcase
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_byte(b, CHK_PREDICT, NO_REPORT);
		end
	endtask

	// Receiver: draw a stall before each report, drop ready for it, then take
	// the next transfer. A hold request overrides the draw with a long hold-off.
	initial begin
		int unsigned stall;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = RX_HOLD_CYCLES;
			end else begin
				if ($urandom_range(0, 47) == 0)
					rx_burst = !rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, 11);
			end
			if (stall != 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready) && !hold_req);
		end
	end

	// Result monitor: compare each report transfer with the oldest one owed.
	always @(posedge clk) begin
		pgmf_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("report with none owed: kind %0d status %02h type %02h",
					result_if.result_kind, result_if.xact_status, result_if.msg_type));
			end else begin
				want = pending_reports.pop_front();
				if (result_if.result_kind !== want.result_kind)
					report_mismatch($sformatf("result_kind got %0d want %0d",
						result_if.result_kind, want.result_kind));
				if (result_if.xact_status !== want.xact_status)
					report_mismatch($sformatf("xact_status got %02h want %02h",
						result_if.xact_status, want.xact_status));
				if (result_if.msg_type !== want.msg_type)
					report_mismatch($sformatf("msg_type got %02h want %02h",
						result_if.msg_type, want.msg_type));
			end
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [7:0]  mtype;
		logic [31:0] mlen;
		int unsigned sel;

		arst_n              = 1'b0;
		stream_if.valid     = 1'b0;
		stream_if.data_byte = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Typed reports are the ones that can be read straight off
		// the framing rules; the rest go through the predictor.
		directed_rows = '{
			// 'Z' with a zero length: flagged as malformed.
			row(CHK_PREDICT, READY_TYPE, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_REPORT,  8'h00, {KIND_MALFORMED, 8'h00, READY_TYPE}),
			// All-ones type with length three, the largest short length.
			row(CHK_PREDICT, 8'hFF, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_REPORT,  8'h03, {KIND_MALFORMED, 8'h00, 8'hFF}),
			// 'Z' with length four: header only, so no status.
			row(CHK_PREDICT, READY_TYPE, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_QUIET,   8'h04, NO_REPORT),
			// 'Z' with a two-byte body: status 'E', then one byte skipped.
			row(CHK_PREDICT, READY_TYPE, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h00, NO_REPORT),
			row(CHK_PREDICT, 8'h06, NO_REPORT),
			row(CHK_REPORT,  TXN_FAILED, {KIND_STATUS, TXN_FAILED, READY_TYPE}),
			row(CHK_PREDICT, 8'hFF, NO_REPORT)
		};
		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].chk, directed_rows[i].want);

		// Pause the sender until every owed report has arrived; drop valid so the
		// last byte is not taken twice.
		stream_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);

		// Starve the result side while the sender keeps offering 'Z' messages
		// back to back: the output buffer fills and the stream must stall.
		hold_req = 1'b1;
		tx_burst = 1'b1;
		repeat (10)
			send_message(READY_TYPE, 32'd5);
		tx_burst = 1'b0;

		// Random part: mostly well-formed messages with random content, a share
		// of 'Z', and some short or empty lengths mixed in.
		while (random_bytes < RANDOM_BYTES) begin
			mtype = ($urandom_range(0, 99) < 35) ? READY_TYPE : 8'($urandom_range(0, 255));
			sel   = $urandom_range(0, 99);
			if (sel < 12)
				mlen = $urandom_range(0, 3);
			else if (sel < 22)
				mlen = 32'd4;
			else if (sel < 26)
				mlen = $urandom_range(5, 120);
			else
				mlen = $urandom_range(5, 16);
			send_message(mtype, mlen);
			random_bytes += 5 + ((mlen < 32'd4) ? 0 : mlen - 32'd4);
		end

		// Drop valid, drain what is owed, then settle and give the verdict.
		stream_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
